### sv/sjf_pkg.sv
// Shared types and constants for the shortest-job-first scheduler.
package sjf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_W        = 16;
    localparam int LEN_W       = 16;
    localparam int KEY_W       = LEN_W + ID_W;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [ID_W-1:0]  id_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_PEEK = 2'd1,
        MODE_POP  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the queue at once.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2,
        CELL_SWAP   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        key_t     key;
    } cell_cmd_t;

    typedef struct packed {
        logic head_valid;
        logic full;
        key_t head_key;
    } queue_status_t;

endpackage

### sv/sjf_cell.sv
// One cell of the sorted waiting queue: holds a single job key and its valid bit.
module sjf_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  sjf_pkg::cell_cmd_t cmd,
    input  sjf_pkg::key_t     left_key,
    input  logic              left_valid,
    input  logic              left_gt,
    input  sjf_pkg::key_t     right_key,
    input  logic              right_valid,
    input  logic              right_gt,
    output sjf_pkg::key_t     key,
    output logic              valid,
    output logic              gt
);

    sjf_pkg::key_t key_reg;
    sjf_pkg::key_t key_next;
    logic          valid_reg;
    logic          valid_next;

    // An empty cell counts as greater than any key, so the row stays monotonic.
    assign gt    = !valid_reg || (key_reg > cmd.key);
    assign key   = key_reg;
    assign valid = valid_reg;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        case (cmd.op)
            sjf_pkg::CELL_INSERT:
            begin
                if (gt)
                begin
                    key_next   = left_gt ? left_key : cmd.key;
                    valid_next = valid_reg | left_valid;
                end
            end
            sjf_pkg::CELL_SHIFT:
            begin
                key_next   = right_key;
                valid_next = right_valid;
            end
            sjf_pkg::CELL_SWAP:
            begin
                // Head leaves and the key goes in at once: the row as seen after
                // the shift is the right neighbour's, so its compare decides.
                if (right_gt)
                begin
                    key_next = gt ? key_reg : cmd.key;
                end
                else
                begin
                    key_next = right_key;
                end
            end
            default:
            begin
                key_next   = key_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

### sv/sjf_chain.sv
// Row of queue cells kept in ascending key order, head at cell zero.
module sjf_chain (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sjf_pkg::cell_cmd_t     cmd,
    output sjf_pkg::queue_status_t stat
);

    sjf_pkg::key_t                   cell_key   [sjf_pkg::QUEUE_DEPTH];
    logic [sjf_pkg::QUEUE_DEPTH-1:0] cell_valid;
    logic [sjf_pkg::QUEUE_DEPTH-1:0] cell_gt;

    genvar i;
    generate
        for (i = 0; i < sjf_pkg::QUEUE_DEPTH; i++)
        begin : g_cell
            sjf_pkg::key_t lk;
            sjf_pkg::key_t rk;
            logic          lv;
            logic          lg;
            logic          rv;
            logic          rg;

            if (i == 0)
            begin : g_first
                assign lk = '0;
                assign lv = 1'b1;
                assign lg = 1'b0;
            end
            else
            begin : g_mid_left
                assign lk = cell_key[i-1];
                assign lv = cell_valid[i-1];
                assign lg = cell_gt[i-1];
            end

            if (i == sjf_pkg::QUEUE_DEPTH - 1)
            begin : g_last
                assign rk = '0;
                assign rv = 1'b0;
                assign rg = 1'b1;
            end
            else
            begin : g_mid_right
                assign rk = cell_key[i+1];
                assign rv = cell_valid[i+1];
                assign rg = cell_gt[i+1];
            end

            sjf_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_key    (lk),
                .left_valid  (lv),
                .left_gt     (lg),
                .right_key   (rk),
                .right_valid (rv),
                .right_gt    (rg),
                .key         (cell_key[i]),
                .valid       (cell_valid[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    assign stat.head_valid = cell_valid[0];
    assign stat.full       = cell_valid[sjf_pkg::QUEUE_DEPTH-1];
    assign stat.head_key   = cell_key[0];

endmodule

### sv/shortest_job_first_scheduler_core.sv
// An accepted beat's result is registered; it shows on the master side in the next cycle.
// Throughput: one beat per cycle unless m_tready stalls; each queue update is one row step.
// The output register frees s_tready whenever the result is taken in the same cycle.
// Reset (rst_n low, asynchronous) empties the current slot and marks every queue cell
// invalid; the block takes beats from the first cycle after reset is released.
// Top level: current-job slot, operation decode and the sorted queue of cells.
module shortest_job_first_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // job_id [15:0], job_length [31:16], current_remaining [47:32]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // result_id [15:0], result_valid [16], status [18:17],
                                   // is_empty [19], zero fill [23:20]
);

    sjf_pkg::cell_cmd_t     cmd;
    sjf_pkg::queue_status_t qstat;

    logic          cur_valid_reg;
    logic          cur_valid_next;
    sjf_pkg::id_t  cur_id_reg;
    sjf_pkg::id_t  cur_id_next;
    sjf_pkg::len_t cur_len_reg;
    sjf_pkg::len_t cur_len_next;
    logic          m_tvalid_reg;
    logic [23:0]   m_tdata_reg;
    logic [23:0]   m_tdata_next;

    logic             accept;
    sjf_pkg::id_t     in_id;
    sjf_pkg::len_t    in_len;
    sjf_pkg::len_t    in_rem;
    sjf_pkg::len_t    head_len;
    sjf_pkg::id_t     res_id;
    logic             res_valid;
    sjf_pkg::status_t status;

    assign in_id    = s_tdata[15:0];
    assign in_len   = s_tdata[31:16];
    assign in_rem   = s_tdata[47:32];
    assign head_len = qstat.head_key[sjf_pkg::KEY_W-1:sjf_pkg::ID_W];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_id_next    = cur_id_reg;
        cur_len_next   = cur_len_reg;
        cmd.op         = sjf_pkg::CELL_HOLD;
        cmd.key        = {in_len, in_id};
        res_id         = '0;
        res_valid      = 1'b0;
        status         = sjf_pkg::STATUS_OK;
        if (accept)
        begin
            case (s_tuser)
                sjf_pkg::MODE_ADD:
                begin
                    if (!cur_valid_reg)
                    begin
                        cur_valid_next = 1'b1;
                        cur_id_next    = in_id;
                        cur_len_next   = in_len;
                    end
                    else if (qstat.full)
                    begin
                        status = sjf_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        cmd.op = sjf_pkg::CELL_INSERT;
                    end
                end
                sjf_pkg::MODE_PEEK:
                begin
                    if (!cur_valid_reg)
                    begin
                        status = sjf_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res_id    = cur_id_reg;
                        // An unstarted current job gives way to a strictly shorter head.
                        if (qstat.head_valid && (in_rem == cur_len_reg) &&
                            (cur_len_reg > head_len))
                        begin
                            cmd.op       = sjf_pkg::CELL_SWAP;
                            cmd.key      = {cur_len_reg, cur_id_reg};
                            cur_id_next  = qstat.head_key[sjf_pkg::ID_W-1:0];
                            cur_len_next = head_len;
                            res_id       = qstat.head_key[sjf_pkg::ID_W-1:0];
                        end
                    end
                end
                sjf_pkg::MODE_POP:
                begin
                    if (!cur_valid_reg)
                    begin
                        status = sjf_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        res_id    = cur_id_reg;
                        if (qstat.head_valid)
                        begin
                            cmd.op       = sjf_pkg::CELL_SHIFT;
                            cur_id_next  = qstat.head_key[sjf_pkg::ID_W-1:0];
                            cur_len_next = head_len;
                        end
                        else
                        begin
                            cur_valid_next = 1'b0;
                            cur_id_next    = '0;
                            cur_len_next   = '0;
                        end
                    end
                end
                default:
                begin
                    status = sjf_pkg::STATUS_OK;
                end
            endcase
        end
        m_tdata_next = {4'b0000, !cur_valid_next, status, res_valid, res_id};
    end

    sjf_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (qstat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_id_reg    <= '0;
            cur_len_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cur_id_reg    <= cur_id_next;
            cur_len_reg   <= cur_len_next;
            if (accept)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### sv/sjf_checker.sv
// Port-level checks for the scheduler core, bound to the top level.
module sjf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A result beat that is held back keeps its contents.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // A reported job always comes with an ok status.
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> m_tdata[18:17] == sjf_pkg::STATUS_OK)
        else $error("job reported with an error status");

    // An empty status means no job was there and none appeared.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[18:17] == sjf_pkg::STATUS_EMPTY |-> m_tdata[19] && !m_tdata[16])
        else $error("empty status without empty flag");

    // After an add there is always a current job, and the result beat follows in the next cycle.
    a_add_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == sjf_pkg::MODE_ADD
        |=> m_tvalid && !m_tdata[19] && !m_tdata[16])
        else $error("add left the scheduler empty");

    // A full status follows only an add.
    a_full_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != sjf_pkg::MODE_ADD
        |=> m_tdata[18:17] != sjf_pkg::STATUS_FULL)
        else $error("full status on a non-add beat");

endmodule

bind shortest_job_first_scheduler_core sjf_checker u_sjf_checker (.*);

### test/shortest_job_first_scheduler_core_tb.sv
// Self-checking testbench for the shortest-job-first scheduler core.
`timescale 1ns / 1ps

module shortest_job_first_scheduler_core_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         MAX_GAP     = 16;
    localparam int         RANDOM_JOBS = 850;
    localparam int         DRAIN_LIMIT = 2000;

    // Result beat as it appears on m_tdata, highest field first.
    typedef struct packed {
        logic [3:0]        fill;
        logic              is_empty;
        sjf_pkg::status_t  status;
        logic              result_valid;
        sjf_pkg::id_t      result_id;
    } sched_result_t;

    class sjf_scoreboard;
        logic          cur_valid;
        sjf_pkg::id_t  cur_id;
        sjf_pkg::len_t cur_len;
        sjf_pkg::key_t waiting[$];
        sched_result_t expected_results[$];
        int            mismatches;

        function new();
            cur_valid  = 1'b0;
            cur_id     = '0;
            cur_len    = '0;
            mismatches = 0;
        endfunction

        // Waiting jobs stay in ascending {length, id} order; equal keys go behind.
        function void insert_waiting(sjf_pkg::key_t key);
            int pos;
            pos = 0;
            while (pos < waiting.size() && waiting[pos] <= key)
                pos++;
            waiting.insert(pos, key);
        endfunction

        function void promote_head();
            sjf_pkg::key_t head;
            head    = waiting.pop_front();
            cur_id  = head[sjf_pkg::ID_W-1:0];
            cur_len = head[sjf_pkg::KEY_W-1:sjf_pkg::ID_W];
        endfunction

        function void note_input(logic [1:0] mode, sjf_pkg::id_t id, sjf_pkg::len_t len,
                                 sjf_pkg::len_t remaining);
            sched_result_t res;
            sjf_pkg::key_t head;
            sjf_pkg::key_t old_key;
            res        = '0;
            res.status = sjf_pkg::STATUS_OK;
            case (mode)
                sjf_pkg::MODE_ADD:
                begin
                    if (!cur_valid)
                    begin
                        cur_valid = 1'b1;
                        cur_id    = id;
                        cur_len   = len;
                    end
                    else if (waiting.size() >= sjf_pkg::QUEUE_DEPTH)
                        res.status = sjf_pkg::STATUS_FULL;
                    else
                        insert_waiting({len, id});
                end
                sjf_pkg::MODE_PEEK:
                begin
                    if (!cur_valid)
                        res.status = sjf_pkg::STATUS_EMPTY;
                    else
                    begin
                        if (waiting.size() > 0)
                        begin
                            head = waiting[0];
                            // Only a job that has not started yet gives way to a shorter one.
                            if (remaining == cur_len &&
                                cur_len > head[sjf_pkg::KEY_W-1:sjf_pkg::ID_W])
                            begin
                                old_key = {cur_len, cur_id};
                                promote_head();
                                insert_waiting(old_key);
                            end
                        end
                        res.result_id    = cur_id;
                        res.result_valid = 1'b1;
                    end
                end
                sjf_pkg::MODE_POP:
                begin
                    if (!cur_valid)
                        res.status = sjf_pkg::STATUS_EMPTY;
                    else
                    begin
                        res.result_id    = cur_id;
                        res.result_valid = 1'b1;
                        if (waiting.size() == 0)
                        begin
                            cur_valid = 1'b0;
                            cur_id    = '0;
                            cur_len   = '0;
                        end
                        else
                            promote_head();
                    end
                end
                default:
                    ;
            endcase
            res.is_empty = !cur_valid;
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [23:0] data);
            sched_result_t act;
            sched_result_t exp;
            act = data;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result beat with nothing expected: %h", $realtime, data);
            end
            else
            begin
                exp = expected_results.pop_front();
                if (act.result_id !== exp.result_id || act.result_valid !== exp.result_valid ||
                    act.status !== exp.status || act.is_empty !== exp.is_empty ||
                    act.fill !== exp.fill)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("%t: mismatch: expected id=%h valid=%b status=%0d empty=%b fill=%h",
                               $realtime, exp.result_id, exp.result_valid, exp.status,
                               exp.is_empty, exp.fill);
                        $display(", got id=%h valid=%b status=%0d empty=%b fill=%h",
                                 act.result_id, act.result_valid, act.status, act.is_empty,
                                 act.fill);
                    end
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    sjf_scoreboard sb;
    logic          send_no_idle;
    logic          recv_no_idle;
    logic          reset_done;

    shortest_job_first_scheduler_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int draw_gap(logic no_idle);
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Holds one input beat until the block takes it, then records the prediction.
    task automatic send_job(logic [1:0] mode, sjf_pkg::id_t id, sjf_pkg::len_t len,
                            sjf_pkg::len_t remaining);
        int gap;
        gap = draw_gap(send_no_idle);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {remaining, len, id};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(mode, id, len, remaining);
    endtask

    function automatic sjf_pkg::len_t pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return sjf_pkg::len_t'($urandom_range(0, 7));
        if (r < 55)
            return '0;
        if (r < 60)
            return '1;
        return sjf_pkg::len_t'($urandom);
    endfunction

    function automatic sjf_pkg::id_t pick_id();
        if ($urandom_range(0, 1))
            return sjf_pkg::id_t'($urandom_range(0, 15));
        return sjf_pkg::id_t'($urandom);
    endfunction

    // One burst of traffic whose mix of adds and removals pushes the queue up or down.
    task automatic run_phase(int count, int add_pct, inout int done);
        int            r;
        sjf_pkg::len_t rem;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < add_pct)
            begin
                send_job(sjf_pkg::MODE_ADD, pick_id(), pick_length(),
                         sjf_pkg::len_t'($urandom));
                done++;
            end
            else if (r < add_pct + 3)
                send_job(MODE_UNUSED, sjf_pkg::id_t'($urandom), sjf_pkg::len_t'($urandom),
                         sjf_pkg::len_t'($urandom));
            else if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: rem = sb.cur_len;
                    6:                rem = sb.cur_len - 1'b1;
                    7:                rem = sb.cur_len + 1'b1;
                    default:          rem = sjf_pkg::len_t'($urandom);
                endcase
                send_job(sjf_pkg::MODE_PEEK, sjf_pkg::id_t'($urandom),
                         sjf_pkg::len_t'($urandom), rem);
                done++;
            end
            else
            begin
                send_job(sjf_pkg::MODE_POP, sjf_pkg::id_t'($urandom),
                         sjf_pkg::len_t'($urandom), sjf_pkg::len_t'($urandom));
                done++;
            end
        end
    endtask

    // Result side: random stalls before each beat, checked against the oldest prediction.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        wait (reset_done === 1'b1);
        forever
        begin
            gap = draw_gap(recv_no_idle);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial
    begin
        int done;
        int wait_cycles;
        int add_pct;
        sb           = new();
        done         = 0;
        wait_cycles  = 0;
        send_no_idle = 1'b0;
        recv_no_idle = 1'b0;
        reset_done   = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= sjf_pkg::MODE_ADD;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reset_done = 1'b1;

        // Directed: operations on an empty scheduler, a full queue and both peek outcomes.
        send_job(sjf_pkg::MODE_PEEK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_job(sjf_pkg::MODE_POP, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_job(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_job(sjf_pkg::MODE_ADD, 16'hFFFF, 16'hFFFF, 16'h0000);
        // Equal lengths arrive with falling ids so the id tie-break is exercised.
        for (int i = 0; i < sjf_pkg::QUEUE_DEPTH; i++)
            send_job(sjf_pkg::MODE_ADD, sjf_pkg::id_t'((15 - i) * 16'h1111),
                     (i == 15) ? 16'hFFFF : sjf_pkg::len_t'(3 - i / 4), 16'hFFFF);
        send_job(sjf_pkg::MODE_ADD, 16'h1234, 16'h0001, 16'h0000);
        send_job(MODE_UNUSED, 16'h0000, 16'h0000, 16'h0000);
        send_job(sjf_pkg::MODE_PEEK, 16'h0000, 16'h0000, 16'h0000);
        send_job(sjf_pkg::MODE_PEEK, 16'h0000, 16'h0000, 16'hFFFF);
        send_job(sjf_pkg::MODE_POP, 16'h0000, 16'h0000, 16'h0000);

        while (done < RANDOM_JOBS)
        begin
            case ($urandom_range(0, 3))
                0:       add_pct = 15;
                1:       add_pct = 45;
                2:       add_pct = 70;
                default: add_pct = 92;
            endcase
            send_no_idle = ($urandom_range(0, 3) == 0);
            recv_no_idle = ($urandom_range(0, 3) == 0);
            run_phase($urandom_range(40, 80), add_pct, done);
        end
        s_tvalid <= 1'b0;

        while (sb.expected_results.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (5) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### shortest_job_first_scheduler_core.f
sv/sjf_pkg.sv
sv/sjf_cell.sv
sv/sjf_chain.sv
sv/shortest_job_first_scheduler_core.sv
sv/sjf_checker.sv
test/shortest_job_first_scheduler_core_tb.sv
